/* sv/h264ab_pkg.sv */
// Shared types and constants for the H.264 Annex-B access unit checker.
// No dependencies; every other file refers to this package by scoped names.
package h264ab_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TYPE_W = 5;

	localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONE       = 8'h01;
	localparam logic [BYTE_W-1:0] BYTE_EMUL_MAX  = 8'h03;
	localparam logic [BYTE_W-1:0] BYTE_EMUL_LOW  = 8'h02;
	localparam logic [BYTE_W-1:0] BYTE_EMUL      = 8'h03;
	localparam logic [BYTE_W-1:0] FORBIDDEN_MASK = 8'h80;
	localparam logic [BYTE_W-1:0] TYPE_MASK      = 8'h1f;

	localparam logic [TYPE_W-1:0] NAL_TYPE_FIRST_SLICE = 5'd1;
	localparam logic [TYPE_W-1:0] NAL_TYPE_IDR         = 5'd5;
	localparam logic [TYPE_W-1:0] NAL_TYPE_SPS         = 5'd7;
	localparam logic [TYPE_W-1:0] NAL_TYPE_PPS         = 5'd8;
	localparam logic [TYPE_W-1:0] NAL_TYPE_LIMIT       = 5'd24;

	localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
	localparam logic [1:0] ZERO_RUN_SC  = 2'd2;
	localparam logic [1:0] NAL_LEN_MIN  = 2'd2;
	localparam logic [1:0] NAL_LEN_HDR  = 2'd1;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic slice;
		logic idr;
		logic sps;
		logic pps;
		logic ps_only;
	} type_flags_t;

	localparam type_flags_t TYPE_FLAGS_RESET = '{
		slice: 1'b0, idr: 1'b0, sps: 1'b0, pps: 1'b0, ps_only: 1'b1
	};

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
		logic              unit_last;
	} item_t;

	typedef struct packed {
		logic        unit_ok;
		type_flags_t flags;
	} result_t;

endpackage

/* sv/h264ab_in_reg.sv */
// Input register stage of the Annex-B checker: holds one byte transfer.
// Depends on h264ab_pkg.
module h264ab_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  h264ab_pkg::item_t   item,
	input  logic                hold,
	output logic                byte_stall,
	output logic                item_valid_s1,
	output h264ab_pkg::item_t   item_s1
);

	logic accept;

	assign byte_stall = hold;
	assign accept     = byte_valid & ~hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= accept | (item_valid_s1 & hold);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

/* sv/h264ab_parse.sv */
// Parser state and per-byte next-state logic of the Annex-B checker.
// Depends on h264ab_pkg.
module h264ab_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  h264ab_pkg::item_t     item_s1,
	output logic                  res_load,
	output h264ab_pkg::result_t   res
);

	h264ab_pkg::phase_t      phase_q, phase_n;
	logic [1:0]              zero_run_q, zero_run_n;
	logic [1:0]              nal_len_q, nal_len_n;
	logic                    esc_q, esc_n;
	logic                    failed_q, failed_n;
	h264ab_pkg::type_flags_t flags_q, flags_n;

	logic [h264ab_pkg::BYTE_W-1:0] b;
	logic [h264ab_pkg::TYPE_W-1:0] t;
	logic                          body_fail;
	logic                          end_fail;

	assign b = item_s1.stream_byte;
	assign t = h264ab_pkg::TYPE_W'(b & h264ab_pkg::TYPE_MASK);

	always_comb begin
		phase_n    = phase_q;
		zero_run_n = zero_run_q;
		nal_len_n  = nal_len_q;
		esc_n      = esc_q;
		failed_n   = failed_q;
		flags_n    = flags_q;
		body_fail  = 1'b0;
		end_fail   = 1'b0;

		if (!failed_q) begin
			unique case (phase_q)
				h264ab_pkg::PH_HEAD: begin
					if (b == h264ab_pkg::BYTE_ZERO
						|| (b & h264ab_pkg::FORBIDDEN_MASK) != h264ab_pkg::BYTE_ZERO
						|| t == '0 || t >= h264ab_pkg::NAL_TYPE_LIMIT) begin
						failed_n = 1'b1;
					end else begin
						if (t >= h264ab_pkg::NAL_TYPE_FIRST_SLICE
							&& t <= h264ab_pkg::NAL_TYPE_IDR)
							flags_n.slice = 1'b1;
						if (t == h264ab_pkg::NAL_TYPE_IDR) flags_n.idr = 1'b1;
						if (t == h264ab_pkg::NAL_TYPE_SPS) flags_n.sps = 1'b1;
						if (t == h264ab_pkg::NAL_TYPE_PPS) flags_n.pps = 1'b1;
						if (t != h264ab_pkg::NAL_TYPE_SPS && t != h264ab_pkg::NAL_TYPE_PPS)
							flags_n.ps_only = 1'b0;
						phase_n    = h264ab_pkg::PH_BODY;
						nal_len_n  = h264ab_pkg::NAL_LEN_HDR;
						zero_run_n = '0;
						esc_n      = 1'b0;
					end
				end
				h264ab_pkg::PH_BODY: begin
					if (b == h264ab_pkg::BYTE_ZERO) begin
						if (zero_run_q != h264ab_pkg::ZERO_RUN_MAX)
							zero_run_n = zero_run_q + 2'd1;
					end else if (b == h264ab_pkg::BYTE_ONE
						&& zero_run_q >= h264ab_pkg::ZERO_RUN_SC) begin
						// start code closes the current NAL unit
						if (esc_q || nal_len_q < h264ab_pkg::NAL_LEN_MIN)
							failed_n = 1'b1;
						phase_n    = h264ab_pkg::PH_HEAD;
						zero_run_n = '0;
						nal_len_n  = '0;
						esc_n      = 1'b0;
					end else begin
						nal_len_n = h264ab_pkg::NAL_LEN_MIN;
						if (esc_q) begin
							if (zero_run_q == '0 && b > h264ab_pkg::BYTE_EMUL_MAX)
								body_fail = 1'b1;
							else
								esc_n = 1'b0;
						end
						if (!body_fail) begin
							if (zero_run_q == h264ab_pkg::ZERO_RUN_MAX) begin
								body_fail = 1'b1;
							end else if (zero_run_q == h264ab_pkg::ZERO_RUN_SC) begin
								if (b <= h264ab_pkg::BYTE_EMUL_LOW)
									body_fail = 1'b1;
								else if (b == h264ab_pkg::BYTE_EMUL)
									esc_n = 1'b1;
							end
						end
						if (!body_fail) zero_run_n = '0;
						if (body_fail) failed_n = 1'b1;
					end
				end
				default: begin
					if (b == h264ab_pkg::BYTE_ZERO) begin
						if (zero_run_q != h264ab_pkg::ZERO_RUN_MAX)
							zero_run_n = zero_run_q + 2'd1;
					end else if (b == h264ab_pkg::BYTE_ONE
						&& zero_run_q >= h264ab_pkg::ZERO_RUN_SC) begin
						phase_n    = h264ab_pkg::PH_HEAD;
						zero_run_n = '0;
					end else begin
						failed_n = 1'b1;
					end
				end
			endcase
		end

		// end of unit: the open NAL unit must close cleanly
		end_fail = failed_n;
		if (!failed_n) begin
			if (phase_n == h264ab_pkg::PH_BODY) begin
				if (esc_n || nal_len_n < h264ab_pkg::NAL_LEN_MIN) end_fail = 1'b1;
			end else begin
				end_fail = 1'b1;
			end
		end

		res.unit_ok = ~end_fail;
		res.flags   = end_fail ? '0 : flags_n;
	end

	assign res_load = step & item_s1.unit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= h264ab_pkg::PH_LEAD;
			zero_run_q <= '0;
			nal_len_q  <= '0;
			esc_q      <= 1'b0;
			failed_q   <= 1'b0;
			flags_q    <= h264ab_pkg::TYPE_FLAGS_RESET;
		end else if (step) begin
			if (item_s1.unit_last) begin
				phase_q    <= h264ab_pkg::PH_LEAD;
				zero_run_q <= '0;
				nal_len_q  <= '0;
				esc_q      <= 1'b0;
				failed_q   <= 1'b0;
				flags_q    <= h264ab_pkg::TYPE_FLAGS_RESET;
			end else begin
				phase_q    <= phase_n;
				zero_run_q <= zero_run_n;
				nal_len_q  <= nal_len_n;
				esc_q      <= esc_n;
				failed_q   <= failed_n;
				flags_q    <= flags_n;
			end
		end
	end

endmodule

/* sv/h264ab_out_reg.sv */
// Result register of the Annex-B checker: holds one verdict until transferred.
// Depends on h264ab_pkg.
module h264ab_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_load,
	input  h264ab_pkg::result_t   res,
	input  logic                  result_stall,
	output logic                  result_valid,
	output logic                  blocked,
	output h264ab_pkg::result_t   res_q
);

	assign blocked = result_valid & result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule

/* sv/h264_annexb_access_unit_checker.sv */
// H.264 Annex-B access unit checker. Feed the access unit one byte per
// transfer on the byte channel and flag its final byte with unit_last; one
// verdict transfer follows on the result channel for every final byte. A byte
// is taken in every cycle unless the byte channel stalls: the byte passes an
// input register, then the parser updates its state and writes the verdict
// into a result register, which holds it on the result channel until it is
// taken. The byte channel stalls only while a final byte waits behind a
// verdict that the result side has not yet taken. unit_ok is 0 for a
// malformed unit (bad leading bytes, short or empty NAL unit, forbidden bit,
// type 0 or 24..31, emulation prevention broken, or no NAL unit at all), and
// then all type flags read 0.
// Depends on h264ab_pkg, h264ab_in_reg, h264ab_parse and h264ab_out_reg.
module h264_annexb_access_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] stream_byte,
	input  logic       unit_last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       unit_ok,
	output logic       has_slice,
	output logic       has_idr,
	output logic       has_sps,
	output logic       has_pps,
	output logic       only_parameter_sets
);

	h264ab_pkg::item_t   item;
	h264ab_pkg::item_t   item_s1;
	h264ab_pkg::result_t res;
	h264ab_pkg::result_t res_q;
	logic                item_valid_s1;
	logic                hold;
	logic                step;
	logic                res_load;
	logic                blocked;

	assign item.stream_byte = stream_byte;
	assign item.unit_last   = unit_last;

	// hold the registered byte only if it would produce a verdict with nowhere to go
	assign hold = item_valid_s1 & item_s1.unit_last & blocked;
	// advance the parser on every registered byte that is not held
	assign step = item_valid_s1 & ~hold;

	h264ab_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.item          (item),
		.hold          (hold),
		.byte_stall    (byte_stall),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	h264ab_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item_s1  (item_s1),
		.res_load (res_load),
		.res      (res)
	);

	h264ab_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res          (res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.blocked      (blocked),
		.res_q        (res_q)
	);

	assign unit_ok             = res_q.unit_ok;
	assign has_slice           = res_q.flags.slice;
	assign has_idr             = res_q.flags.idr;
	assign has_sps             = res_q.flags.sps;
	assign has_pps             = res_q.flags.pps;
	assign only_parameter_sets = res_q.flags.ps_only;

endmodule
